FILE: src/bilinear_quad_grid_generator_top_macros.svh
// Assertion helpers for the grid generator.
// All assertions are clocked on clk; the first form is masked while arst_n is low.
`ifndef BILINEAR_QUAD_GRID_GENERATOR_TOP_MACROS_SVH
`define BILINEAR_QUAD_GRID_GENERATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define BQG_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define BQG_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BQG_ASSERT(label, prop, msg)
`define BQG_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

FILE: src/bqg_pkg.sv
package bqg_pkg;

	// Largest resolution honored; the resolution register is RES_W bits wide and keeps only the low bits of a write.
	localparam int MAX_RESOLUTION = 255;

	localparam int RES_W      = 8;
	localparam int CORNER_W   = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int COORD_W    = 24;
	localparam int TEX_W      = 17;
	localparam int IDX_W      = 16;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_TOP_LEFT     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOP_RIGHT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_RIGHT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_LEFT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RESOLUTION   = 3'd4;

	localparam logic [RES_W-1:0] RES_RESET = 8'd10;

	// Divider: quotient bits produced one per cycle.
	localparam int DIV_NUM_W = 40;
	localparam int DIV_DEN_W = 16;
	localparam int DIV_STEPS = 24;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef struct packed {
		logic accept;
		logic calc_a;
		logic calc_b;
		logic calc_c;
		logic div_start;
		logic div_step;
		logic res_load;
	} dp_cmd_t;

endpackage

FILE: src/bqg_ifs.sv
interface bqg_in_if;
	import bqg_pkg::*;

	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface bqg_out_if;
	import bqg_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] vertex_x;
	logic signed [COORD_W-1:0] vertex_y;
	logic [TEX_W-1:0]          tex_u;
	logic [TEX_W-1:0]          tex_v;
	logic [IDX_W-1:0]          vertex_index;
	logic                      last_point;

	modport source (
		output valid, output vertex_x, output vertex_y, output tex_u, output tex_v,
		output vertex_index, output last_point, input ready
	);
	modport sink (
		input valid, input vertex_x, input vertex_y, input tex_u, input tex_v,
		input vertex_index, input last_point, output ready
	);
endinterface

FILE: src/bqg_div.sv
// Restoring divider, one quotient bit per step. The upper part of num must be
// below den so the quotient fits in DIV_STEPS bits.
module bqg_div (
	input  logic                             clk,
	input  logic                             start,
	input  logic                             step,
	input  logic [bqg_pkg::DIV_NUM_W-1:0]    num,
	input  logic [bqg_pkg::DIV_DEN_W-1:0]    den,
	output logic [bqg_pkg::DIV_STEPS-1:0]    quo,
	output logic                             rem_nz
);
	import bqg_pkg::*;

	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_STEPS-1:0] shift_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W:0]   trial;
	logic                 fits;

	assign trial = {rem_q, shift_q[DIV_STEPS-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q   <= num[DIV_NUM_W-1 -: DIV_DEN_W];
			shift_q <= num[DIV_STEPS-1:0];
			den_q   <= den;
		end else if (step) begin
			rem_q   <= fits ? DIV_DEN_W'(trial - {1'b0, den_q}) : trial[DIV_DEN_W-1:0];
			shift_q <= {shift_q[DIV_STEPS-2:0], fits};
		end
	end

	assign quo    = shift_q;
	assign rem_nz = rem_q != '0;
endmodule

FILE: src/bqg_datapath.sv
module bqg_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bqg_pkg::dp_cmd_t                  cmd,
	input  logic                              restart,
	input  logic                              cfg_wr_en,
	input  logic [bqg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bqg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output logic signed [bqg_pkg::COORD_W-1:0] vertex_x,
	output logic signed [bqg_pkg::COORD_W-1:0] vertex_y,
	output logic [bqg_pkg::TEX_W-1:0]         tex_u,
	output logic [bqg_pkg::TEX_W-1:0]         tex_v,
	output logic [bqg_pkg::IDX_W-1:0]         vertex_index,
	output logic                              last_point
);
	import bqg_pkg::*;

	logic [CORNER_W-1:0] tl_q, tr_q, br_q, bl_q;
	logic [RES_W-1:0]    res_q;
	logic [RES_W-1:0]    r_eff;
	logic [RES_W-1:0]    row_q, col_q;
	logic [RES_W-1:0]    pt_i_q, pt_j_q;
	logic [RES_W-1:0]    ci, cj;
	logic                wrap, at_last;
	logic                last_q;
	logic [IDX_W-1:0]    idx_s1;
	logic [DIV_DEN_W-1:0] rr_s1;
	logic signed [25:0]  r_s26, i_s26;
	logic signed [35:0]  r_s36, j_s36;

	logic [DIV_STEPS-1:0] vq [2];
	logic                 vrem_nz [2];
	logic                 vneg_q [2];
	logic [COORD_W-1:0]   vres [2];
	logic [DIV_STEPS-1:0] quo_u, quo_v;
	logic [DIV_NUM_W-1:0] num_u, num_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tl_q  <= '0;
			tr_q  <= '0;
			br_q  <= '0;
			bl_q  <= '0;
			res_q <= RES_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_TOP_LEFT:     tl_q  <= cfg_wdata;
				CFG_TOP_RIGHT:    tr_q  <= cfg_wdata;
				CFG_BOTTOM_RIGHT: br_q  <= cfg_wdata;
				CFG_BOTTOM_LEFT:  bl_q  <= cfg_wdata;
				CFG_RESOLUTION:   res_q <= cfg_wdata[RES_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		r_eff = res_q;
		if (res_q == '0) r_eff = RES_W'(1);
		if (32'(res_q) > MAX_RESOLUTION) r_eff = RES_W'(MAX_RESOLUTION);
	end

	// Grid point selection; an out-of-range counter (resolution lowered) restarts too.
	assign wrap    = restart || (row_q > r_eff) || (col_q > r_eff);
	assign ci      = wrap ? '0 : row_q;
	assign cj      = wrap ? '0 : col_q;
	assign at_last = (ci == r_eff) && (cj == r_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cmd.accept) begin
			if (at_last) begin
				row_q <= '0;
				col_q <= '0;
			end else if (cj == r_eff) begin
				row_q <= ci + RES_W'(1);
				col_q <= '0;
			end else begin
				row_q <= ci;
				col_q <= cj + RES_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pt_i_q <= ci;
			pt_j_q <= cj;
			last_q <= at_last;
		end
		if (cmd.calc_a) begin
			idx_s1 <= {8'd0, pt_i_q} * ({8'd0, r_eff} + 16'd1) + {8'd0, pt_j_q};
			rr_s1  <= {8'd0, r_eff} * {8'd0, r_eff};
		end
	end

	assign r_s26 = signed'(26'(r_eff));
	assign i_s26 = signed'(26'(pt_i_q));
	assign r_s36 = signed'(36'(r_eff));
	assign j_s36 = signed'(36'(pt_j_q));

	// One lane per axis: edge points scaled by R, then the vertex scaled by R*R.
	for (genvar ax = 0; ax < 2; ax++) begin : g_axis
		logic signed [15:0]  tl, tr, br, bl;
		logic signed [25:0]  tlr_s1, dli_s1, trr_s1, dri_s1;
		logic signed [25:0]  left_s2, right_s2;
		logic signed [35:0]  lr_s3, dj_s3;
		logic signed [35:0]  p;
		logic [31:0]         pmag;
		logic [DIV_NUM_W-1:0] num;
		logic [COORD_W-1:0]  qadj;

		assign tl = signed'(tl_q[ax*16 +: 16]);
		assign tr = signed'(tr_q[ax*16 +: 16]);
		assign br = signed'(br_q[ax*16 +: 16]);
		assign bl = signed'(bl_q[ax*16 +: 16]);

		always_ff @(posedge clk) begin
			if (cmd.calc_a) begin
				tlr_s1 <= 26'(tl) * r_s26;
				dli_s1 <= (26'(bl) - 26'(tl)) * i_s26;
				trr_s1 <= 26'(tr) * r_s26;
				dri_s1 <= (26'(br) - 26'(tr)) * i_s26;
			end
			if (cmd.calc_b) begin
				left_s2  <= tlr_s1 + dli_s1;
				right_s2 <= trr_s1 + dri_s1;
			end
			if (cmd.calc_c) begin
				lr_s3 <= 36'(left_s2) * r_s36;
				dj_s3 <= (36'(right_s2) - 36'(left_s2)) * j_s36;
			end
			if (cmd.div_start) vneg_q[ax] <= p[35];
		end

		assign p    = lr_s3 + dj_s3;
		assign pmag = p[35] ? 32'(-p) : 32'(p);
		assign num  = {pmag, 8'd0};

		bqg_div u_div (
			.clk    (clk),
			.start  (cmd.div_start),
			.step   (cmd.div_step),
			.num    (num),
			.den    (rr_s1),
			.quo    (vq[ax]),
			.rem_nz (vrem_nz[ax])
		);

		// Floor for negative values: -(q + 1) when the division was inexact.
		assign qadj     = vq[ax] + COORD_W'(vrem_nz[ax]);
		assign vres[ax] = vneg_q[ax] ? (~qadj + COORD_W'(1)) : vq[ax];
	end

	assign num_u = {16'd0, pt_j_q, 16'd0};
	assign num_v = {16'd0, pt_i_q, 16'd0};

	bqg_div u_div_u (
		.clk    (clk),
		.start  (cmd.div_start),
		.step   (cmd.div_step),
		.num    (num_u),
		.den    ({8'd0, r_eff}),
		.quo    (quo_u),
		.rem_nz ()
	);

	bqg_div u_div_v (
		.clk    (clk),
		.start  (cmd.div_start),
		.step   (cmd.div_step),
		.num    (num_v),
		.den    ({8'd0, r_eff}),
		.quo    (quo_v),
		.rem_nz ()
	);

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			vertex_x     <= signed'(vres[0]);
			vertex_y     <= signed'(vres[1]);
			tex_u        <= quo_u[TEX_W-1:0];
			tex_v        <= quo_v[TEX_W-1:0];
			vertex_index <= idx_s1;
			last_point   <= last_q;
		end
	end
endmodule

FILE: src/bqg_ctrl.sv
module bqg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              out_ready,
	output logic              in_ready,
	output logic              out_valid,
	output bqg_pkg::dp_cmd_t  cmd
);
	import bqg_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CALC_A,
		S_CALC_B,
		S_CALC_C,
		S_DIV_START,
		S_DIVIDE,
		S_DONE
	} state_t;

	state_t               state_q;
	logic                 in_ready_q;
	logic                 out_valid_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 out_free;

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (cmd.res_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						in_ready_q <= 1'b0;
						state_q    <= S_CALC_A;
					end
				end
				S_CALC_A:    state_q <= S_CALC_B;
				S_CALC_B:    state_q <= S_CALC_C;
				S_CALC_C:    state_q <= S_DIV_START;
				S_DIV_START: begin
					cnt_q   <= DIV_CNT_W'(DIV_STEPS - 1);
					state_q <= S_DIVIDE;
				end
				S_DIVIDE: begin
					if (cnt_q == '0) state_q <= S_DONE;
					else cnt_q <= cnt_q - DIV_CNT_W'(1);
				end
				S_DONE: begin
					// result register frees up on the same edge as its transfer
					if (out_free) begin
						in_ready_q  <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.accept    = in_valid && in_ready_q;
		cmd.calc_a    = state_q == S_CALC_A;
		cmd.calc_b    = state_q == S_CALC_B;
		cmd.calc_c    = state_q == S_CALC_C;
		cmd.div_start = state_q == S_DIV_START;
		cmd.div_step  = state_q == S_DIVIDE;
		cmd.res_load  = (state_q == S_DONE) && out_free;
	end
endmodule

FILE: src/bilinear_quad_grid_generator_top.sv
// Bilinear quad grid generator.
// step_in: one transfer asks for the next grid point; restart = 1 goes back to
// row 0, column 0 first. vtx_out: one transfer per step carries the vertex
// (signed Q16.8, rounded down), texture coordinates in Q1.16, the linear index
// and a flag on the final grid point. The walk is row-major and wraps to the
// origin after the last point.
// Corners and resolution are written through the cfg_* port; the user must write
// them only while no step is in flight, which the block itself does not enforce; a resolution of zero acts as one.
// Each step runs from its input transfer through three arithmetic stages, a
// divider load, the bit-serial dividers (one quotient bit per cycle) and the
// result load, after which step_in is ready again; no new step is accepted
// before then. A finished result sits in the output register while the next
// step is accepted; a stalled receiver holds up only the loading of the
// following result.
// Reset: corners 0, resolution 10, walk at the origin, step_in ready.
module bilinear_quad_grid_generator_top (
	input  logic                           clk,
	input  logic                           arst_n,
	bqg_in_if.sink                         step_in,
	bqg_out_if.source                      vtx_out,
	input  logic                           cfg_wr_en,
	input  logic [bqg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bqg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import bqg_pkg::*;

	`include "bilinear_quad_grid_generator_top_macros.svh"

	dp_cmd_t cmd;

	bqg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (step_in.valid),
		.out_ready (vtx_out.ready),
		.in_ready  (step_in.ready),
		.out_valid (vtx_out.valid),
		.cmd       (cmd)
	);

	bqg_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.restart      (step_in.restart),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.vertex_x     (vtx_out.vertex_x),
		.vertex_y     (vtx_out.vertex_y),
		.tex_u        (vtx_out.tex_u),
		.tex_v        (vtx_out.tex_v),
		.vertex_index (vtx_out.vertex_index),
		.last_point   (vtx_out.last_point)
	);

	`BQG_ASSERT(a_one_in_flight, step_in.valid && step_in.ready |=> !step_in.ready, "second step accepted while busy")
	`BQG_ASSERT(a_no_overwrite, cmd.res_load |-> (!vtx_out.valid || vtx_out.ready), "result register overwritten")
	`BQG_ASSERT(a_last_tex, vtx_out.valid && vtx_out.last_point |-> (vtx_out.tex_u == 17'd65536) && (vtx_out.tex_v == 17'd65536), "last point without full texture coordinates")
	`BQG_ASSERT(a_one_stage, $onehot0({cmd.calc_a, cmd.calc_b, cmd.calc_c, cmd.div_start, cmd.div_step, cmd.res_load}), "overlapping datapath commands")
endmodule
